FILE: rtl/mah_pkg.sv
// shared types, constants and helper functions of the multi-argument hash
package mah_pkg;

	// e*pi as an ieee double, rounded to nearest at elaboration
	localparam logic [63:0] K_BITS = $realtobits(2.718281828459045235360287 * 3.14159265358979323846);
	localparam logic [52:0] K_SIG = {1'b1, K_BITS[51:0]};
	localparam logic signed [12:0] K_EXP = 13'(int'(K_BITS[62:52]) - 1023);

	localparam logic [31:0] LCG_MUL = 32'd1664525;
	localparam logic [31:0] LCG_ADD = 32'd1013904223;
	localparam logic [31:0] TEMPER_B = 32'h9d2c5680;
	localparam logic [31:0] TEMPER_C = 32'hefc60000;

	// one mixed word handed from the front to the back
	typedef struct packed {
		logic [31:0] mix;
		logic        last;
	} mah_item_t;

	localparam logic [7:0] PERM_TAB [256] = '{
		8'd148, 8'd201, 8'd203, 8'd34,  8'd85,  8'd225, 8'd163, 8'd200, 8'd174, 8'd137,
		8'd51,  8'd24,  8'd19,  8'd252, 8'd107, 8'd173, 8'd110, 8'd251, 8'd149, 8'd69,
		8'd180, 8'd152, 8'd141, 8'd132, 8'd22,  8'd20,  8'd147, 8'd219, 8'd37,  8'd46,
		8'd154, 8'd114, 8'd59,  8'd49,  8'd155, 8'd161, 8'd239, 8'd77,  8'd47,  8'd10,
		8'd70,  8'd227, 8'd53,  8'd235, 8'd30,  8'd188, 8'd143, 8'd73,  8'd88,  8'd193,
		8'd214, 8'd194, 8'd18,  8'd120, 8'd176, 8'd36,  8'd212, 8'd84,  8'd211, 8'd142,
		8'd167, 8'd57,  8'd153, 8'd71,  8'd159, 8'd151, 8'd126, 8'd115, 8'd229, 8'd124,
		8'd172, 8'd101, 8'd79,  8'd183, 8'd32,  8'd38,  8'd68,  8'd11,  8'd67,  8'd109,
		8'd221, 8'd3,   8'd4,   8'd61,  8'd122, 8'd94,  8'd72,  8'd117, 8'd12,  8'd240,
		8'd199, 8'd76,  8'd118, 8'd5,   8'd48,  8'd197, 8'd128, 8'd62,  8'd119, 8'd89,
		8'd14,  8'd45,  8'd226, 8'd195, 8'd80,  8'd50,  8'd40,  8'd192, 8'd60,  8'd65,
		8'd166, 8'd106, 8'd90,  8'd215, 8'd213, 8'd232, 8'd250, 8'd207, 8'd104, 8'd52,
		8'd182, 8'd29,  8'd157, 8'd103, 8'd242, 8'd97,  8'd111, 8'd17,  8'd8,   8'd175,
		8'd254, 8'd108, 8'd208, 8'd224, 8'd191, 8'd112, 8'd105, 8'd187, 8'd43,  8'd56,
		8'd185, 8'd243, 8'd196, 8'd156, 8'd246, 8'd249, 8'd184, 8'd7,   8'd135, 8'd6,
		8'd158, 8'd82,  8'd130, 8'd234, 8'd206, 8'd255, 8'd160, 8'd236, 8'd171, 8'd230,
		8'd42,  8'd98,  8'd54,  8'd74,  8'd209, 8'd205, 8'd33,  8'd177, 8'd15,  8'd138,
		8'd178, 8'd44,  8'd116, 8'd96,  8'd140, 8'd253, 8'd233, 8'd125, 8'd21,  8'd133,
		8'd136, 8'd86,  8'd245, 8'd58,  8'd23,  8'd1,   8'd75,  8'd165, 8'd92,  8'd217,
		8'd39,  8'd0,   8'd218, 8'd91,  8'd179, 8'd55,  8'd238, 8'd170, 8'd134, 8'd83,
		8'd25,  8'd189, 8'd216, 8'd100, 8'd129, 8'd150, 8'd241, 8'd210, 8'd123, 8'd99,
		8'd2,   8'd164, 8'd16,  8'd220, 8'd121, 8'd139, 8'd168, 8'd64,  8'd190, 8'd9,
		8'd31,  8'd228, 8'd95,  8'd247, 8'd244, 8'd81,  8'd102, 8'd145, 8'd204, 8'd146,
		8'd26,  8'd87,  8'd113, 8'd198, 8'd181, 8'd127, 8'd237, 8'd169, 8'd28,  8'd93,
		8'd27,  8'd41,  8'd231, 8'd248, 8'd78,  8'd162, 8'd13,  8'd186, 8'd63,  8'd66,
		8'd131, 8'd202, 8'd35,  8'd144, 8'd222, 8'd223
	};

	// xorshift and mask tempering of the final seed
	function automatic logic [31:0] temper(input logic [31:0] s);
		logic [31:0] t;
		t = s ^ (s >> 11);
		t = t ^ ((t << 7) & TEMPER_B);
		t = t ^ ((t << 15) & TEMPER_C);
		t = t ^ (t >> 18);
		return t;
	endfunction

endpackage

FILE: rtl/mah_front.sv
// front end: takes arguments and turns each into a 32-bit mix word
module mah_front import mah_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [63:0] arg_bits,
	input  logic        arg_last,
	input  logic        in_valid,
	output logic        in_ready,
	output mah_item_t   push_item,
	output logic        push_valid,
	input  logic        push_ready
);

	typedef enum logic [2:0] {
		F_IDLE, F_NORM_A, F_MUL, F_ROUND, F_NORM_M, F_SCALE, F_MIX, F_PUSH
	} fstate_t;

	fstate_t state_q;
	logic                sign_q;
	logic                last_q;
	logic signed [12:0]  exp_q;
	logic [52:0]         sig_q;
	logic [105:0]        acc_q;
	logic [53:0]         prod_q;
	logic [5:0]          psh_q;
	logic [2:0]          cnt_q;
	logic [53:0]         m_q;
	logic signed [12:0]  z_q;
	logic [84:0]         q_q;
	logic [31:0]         mix_q;

	// argument decode
	logic [10:0] a_exp;
	logic [51:0] a_man;
	assign a_exp = arg_bits[62:52];
	assign a_man = arg_bits[51:0];

	// one 27x27 partial product per cycle
	logic [26:0] op_a, op_k;
	logic [53:0] prod_d;
	logic [5:0]  psh_d;
	always_comb begin
		op_a   = cnt_q[1] ? {1'b0, sig_q[52:27]} : sig_q[26:0];
		op_k   = cnt_q[0] ? {1'b0, K_SIG[52:27]} : K_SIG[26:0];
		prod_d = op_a * op_k;
		psh_d  = (cnt_q[1] & cnt_q[0]) ? 6'd54 : ((cnt_q[1] | cnt_q[0]) ? 6'd27 : 6'd0);
	end

	// rounding of the product to double, subnormal range included
	logic [105:0]       nm, shm;
	logic signed [12:0] eu, eb, z_d;
	logic [5:0]         shamt;
	logic               lost, rg, rs;
	logic [52:0]        top;
	logic [53:0]        rnd;
	always_comb begin
		nm    = acc_q[105] ? acc_q : {acc_q[104:0], 1'b0};
		eu    = exp_q + K_EXP + 13'(acc_q[105]);
		eb    = eu + 13'sd1023;
		shamt = (eb[12] || eb == 13'sd0) ? 6'(13'sd1 - eb) : 6'd0;
		shm   = nm >> shamt;
		lost  = |(nm & ~({106{1'b1}} << shamt));
		top   = shm[105:53];
		rg    = shm[52];
		rs    = (|shm[51:0]) | lost;
		rnd   = {1'b0, top} + 54'(rg & (rs | top[0]));
		z_d   = eu - 13'sd52 + 13'(shamt);
	end

	// exponent of the leading bit, overflow means infinity
	logic signed [12:0] ee;
	logic               ovf;
	assign ee  = z_q + 13'sd52;
	assign ovf = ee > 13'sd1023;

	// fraction times 2^32-1, rounded to double, truncated
	logic [84:0]        q_d;
	logic [52:0]        qk;
	logic               qg, qs;
	logic [53:0]        qr;
	logic [31:0]        ilow, lo;
	logic signed [12:0] exv;
	logic [31:0]        mix_d;
	always_comb begin
		q_d = {m_q[52:0], 32'b0} - 85'(m_q[52:0]);
		if (q_q[84]) begin
			qk = q_q[84:32];
			qg = q_q[31];
			qs = |q_q[30:0];
		end else begin
			qk = q_q[83:31];
			qg = q_q[30];
			qs = |q_q[29:0];
		end
		qr    = {1'b0, qk} + 54'(qg & (qs | qk[0]));
		ilow  = q_q[84] ? qr[52:21] : qr[53:22];
		lo    = sign_q ? (32'd0 - ilow) : ilow;
		exv   = z_q + 13'sd53;
		mix_d = lo ^ {{19{exv[12]}}, exv};
	end

	assign in_ready   = (state_q == F_IDLE);
	assign push_valid = (state_q == F_PUSH);
	assign push_item  = '{mix: mix_q, last: last_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= 3'd0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						sign_q <= arg_bits[63];
						last_q <= arg_last;
						acc_q  <= '0;
						cnt_q  <= 3'd0;
						if (a_exp == 11'h7ff || (a_exp == 11'd0 && a_man == 52'd0)) begin
							mix_q   <= 32'd0;
							state_q <= F_PUSH;
						end else if (a_exp == 11'd0) begin
							sig_q   <= {1'b0, a_man};
							exp_q   <= -13'sd1022;
							state_q <= F_NORM_A;
						end else begin
							sig_q   <= {1'b1, a_man};
							exp_q   <= 13'({2'b00, a_exp}) - 13'sd1023;
							state_q <= F_MUL;
						end
					end
				end
				F_NORM_A: begin
					if (sig_q[52]) begin
						state_q <= F_MUL;
					end else begin
						sig_q <= {sig_q[51:0], 1'b0};
						exp_q <= exp_q - 13'sd1;
					end
				end
				F_MUL: begin
					if (cnt_q != 3'd0)
						acc_q <= acc_q + (106'(prod_q) << psh_q);
					prod_q <= prod_d;
					psh_q  <= psh_d;
					if (cnt_q == 3'd4)
						state_q <= F_ROUND;
					else
						cnt_q <= cnt_q + 3'd1;
				end
				F_ROUND: begin
					m_q     <= rnd;
					z_q     <= z_d;
					state_q <= F_NORM_M;
				end
				F_NORM_M: begin
					if (m_q == 54'd0) begin
						mix_q   <= 32'd0;
						state_q <= F_PUSH;
					end else if (m_q[53]) begin
						m_q <= m_q >> 1;
						z_q <= z_q + 13'sd1;
					end else if (!m_q[52]) begin
						m_q <= {m_q[52:0], 1'b0};
						z_q <= z_q - 13'sd1;
					end else if (ovf) begin
						mix_q   <= 32'd0;
						state_q <= F_PUSH;
					end else begin
						state_q <= F_SCALE;
					end
				end
				F_SCALE: begin
					q_q     <= q_d;
					state_q <= F_MIX;
				end
				F_MIX: begin
					mix_q   <= mix_d;
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (push_ready)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/mah_fifo.sv
// small register queue between the front and the back
module mah_fifo import mah_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  mah_item_t wr_item,
	input  logic      wr_valid,
	output logic      wr_ready,
	output mah_item_t rd_item,
	output logic      rd_valid,
	input  logic      rd_ready
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	mah_item_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_wr, do_rd;

	assign wr_ready = (count_q != CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + CW'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

FILE: rtl/mah_back.sv
// back end: seed fold, tempering, byte permutation and result register
module mah_back import mah_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  mah_item_t   pop_item,
	input  logic        pop_valid,
	output logic        pop_ready,
	output logic [31:0] hash_value,
	output logic        out_valid,
	input  logic        out_ready
);

	typedef enum logic [2:0] {
		B_IDLE, B_TEMP, B_P0, B_P1, B_P2, B_P3, B_OUT
	} bstate_t;

	bstate_t     state_q;
	logic [31:0] seed_q;
	logic [31:0] t_q;
	logic [31:0] o_q;
	logic [31:0] seed_d;

	assign seed_d     = 32'(seed_q * LCG_MUL) + pop_item.mix + LCG_ADD;
	assign pop_ready  = (state_q == B_IDLE);
	assign out_valid  = (state_q == B_OUT);
	assign hash_value = o_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			seed_q  <= 32'd0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						if (pop_item.last) begin
							t_q     <= seed_d;
							seed_q  <= 32'd0;
							state_q <= B_TEMP;
						end else begin
							seed_q <= seed_d;
						end
					end
				end
				B_TEMP: begin
					t_q     <= temper(t_q);
					state_q <= B_P0;
				end
				B_P0: begin
					o_q[31:24] <= PERM_TAB[t_q[7:0]];
					state_q    <= B_P1;
				end
				B_P1: begin
					o_q[23:16] <= PERM_TAB[t_q[15:8] + o_q[31:24]];
					state_q    <= B_P2;
				end
				B_P2: begin
					o_q[15:8] <= PERM_TAB[t_q[23:16] + o_q[23:16]];
					state_q   <= B_P3;
				end
				B_P3: begin
					o_q[7:0] <= PERM_TAB[t_q[31:24] + o_q[15:8]];
					state_q  <= B_OUT;
				end
				B_OUT: begin
					if (out_ready)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/multi_argument_hash.sv
// top level of the multi-argument hash
// Folds a run of ieee double arguments, one per input transfer with tlast on
// the final one, into a 32-bit hash sent as one output transfer per run.
// Each argument is multiplied by e*pi in double precision, split into a
// fraction and an exponent, scaled and folded into a running seed by a
// linear congruential step; the last argument triggers tempering, a chained
// byte permutation and the output, and clears the seed. The front end takes
// one argument at a time: a normal argument passes the four-pass 27x27
// multiplier and the rounding steps; a subnormal argument or a product that
// rounds into the subnormal range adds normalization, one bit of shift per
// step. The back end folds one argument at a time, and the last of a run then
// passes tempering, the byte permutation and the output; the queue between
// them lets the front keep working while a hash waits to be taken.
module multi_argument_hash import mah_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [63:0] arg_bits
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // [31:0] hash_value
);

	mah_item_t fq_wr_item, fq_rd_item;
	logic      fq_wr_valid, fq_wr_ready;
	logic      fq_rd_valid, fq_rd_ready;

	// argument decode, multiply and mix word
	mah_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.arg_bits   (s_axis_tdata),
		.arg_last   (s_axis_tlast),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.push_item  (fq_wr_item),
		.push_valid (fq_wr_valid),
		.push_ready (fq_wr_ready)
	);

	// mix words waiting for the seed fold
	mah_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_item  (fq_wr_item),
		.wr_valid (fq_wr_valid),
		.wr_ready (fq_wr_ready),
		.rd_item  (fq_rd_item),
		.rd_valid (fq_rd_valid),
		.rd_ready (fq_rd_ready)
	);

	// seed fold and final hash
	mah_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_item   (fq_rd_item),
		.pop_valid  (fq_rd_valid),
		.pop_ready  (fq_rd_ready),
		.hash_value (m_axis_tdata),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready)
	);

endmodule

FILE: rtl/mah_checker.sv
// port-level checks of the multi-argument hash, bound to the top level
module mah_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	// runs whose last argument went in but whose hash is not yet out
	logic [4:0] pending_q;
	logic       in_last_xfer, out_xfer;

	assign in_last_xfer = s_axis_tvalid && s_axis_tready && s_axis_tlast;
	assign out_xfer     = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pending_q <= 5'd0;
		else if (in_last_xfer && !out_xfer)
			pending_q <= pending_q + 5'd1;
		else if (out_xfer && !in_last_xfer)
			pending_q <= pending_q - 5'd1;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("hash dropped or changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pending_q != 5'd0)
		else $error("hash without a finished run");

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("front end took a second argument while busy");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 5'd31)
		else $error("pending run count out of range");

endmodule

bind multi_argument_hash mah_checker u_mah_checker (.*);

FILE: dv/tb.sv
// testbench for the multi-argument hash: directed and random runs against a predictor
`timescale 1ns / 1ps

module tb;
	import mah_pkg::*;

	typedef struct {
		logic [63:0] arg;
		logic        last;
	} arg_row_t;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ARGS    = 830;
	localparam int QUIET_ARGS     = 120;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;   // [63:0] arg_bits
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [31:0] hash_value

	logic [31:0] hash_q[$];      // hashes still to come out
	logic [31:0] model_seed;
	int          errors;
	int          idle_cycles;
	bit          quiet;          // no idling on either side

	multi_argument_hash DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// directed arguments: signed zeros, specials, extremes, subnormal products
	arg_row_t directed_rows[] = '{
		'{64'h0000000000000000, 1'b1},   // zero alone
		'{64'h8000000000000000, 1'b1},   // negative zero
		'{64'h7ff0000000000000, 1'b1},   // +inf
		'{64'hfff0000000000000, 1'b0},   // -inf, run continues
		'{64'h7ff8000000000001, 1'b1},   // nan
		'{64'h7fefffffffffffff, 1'b1},   // largest double, product overflows
		'{64'h0000000000000001, 1'b1},   // smallest subnormal
		'{64'h800fffffffffffff, 1'b1},   // largest negative subnormal
		'{64'h3ff0000000000000, 1'b0},   // 1.0
		'{64'hbff0000000000000, 1'b1},   // -1.0, negative fraction
		'{64'h0010000000000000, 1'b1},   // smallest normal, product normal
		'{64'h0008000000000000, 1'b1},   // subnormal argument, product normal
		'{64'h7fc0000000000000, 1'b1},   // 2^1021, product overflows
		'{64'hffffffffffffffff, 1'b0},   // all ones (nan)
		'{64'h5555555555555555, 1'b0},
		'{64'haaaaaaaaaaaaaaaa, 1'b1},
		'{64'h41efffffffe00000, 1'b1}    // 2^32-1
	};

	// mix word of one argument: product with e*pi, fraction/exponent split, scaled
	function automatic logic [31:0] arg_mix(input logic [63:0] arg);
		real         prod, scaled;
		logic [63:0] pb, sb;
		logic [51:0] mant;
		logic [52:0] sig;
		logic [63:0] whole;
		int          ex, k, sh;
		prod = $bitstoreal(arg) * $bitstoreal(K_BITS);
		pb = $realtobits(prod);
		mant = pb[51:0];
		if (pb[62:52] == 11'h7ff || (pb[62:52] == 11'd0 && mant == 52'd0))
			return 32'd0;
		if (pb[62:52] != 11'd0) begin
			ex = int'(pb[62:52]) - 1022;
		end else begin
			k = 51;
			while (k > 0 && !mant[k])
				k--;
			ex = k - 1073;
			mant = mant << (52 - k);
		end
		// magnitude of fraction scaled by 2^32-1, then truncated from its bits
		scaled = $bitstoreal({1'b0, 11'd1022, mant}) * 4294967295.0;
		sb = $realtobits(scaled);
		sig = {1'b1, sb[51:0]};
		sh = 1075 - int'(sb[62:52]);
		whole = 64'(sig) >> sh;
		if (pb[63])
			whole = -whole;
		return whole[31:0] ^ 32'(ex);
	endfunction

	function automatic logic [31:0] seed_to_hash(input logic [31:0] s);
		logic [7:0] o3, o2, o1, o0;
		s = s ^ (s >> 11);
		s = s ^ ((s << 7) & TEMPER_B);
		s = s ^ ((s << 15) & TEMPER_C);
		s = s ^ (s >> 18);
		o3 = PERM_TAB[s[7:0]];
		o2 = PERM_TAB[8'(s[15:8] + o3)];
		o1 = PERM_TAB[8'(s[23:16] + o2)];
		o0 = PERM_TAB[8'(s[31:24] + o1)];
		return {o3, o2, o1, o0};
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch: %s got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic idle_burst();
		int n;
		if (quiet || $urandom_range(0, 5) != 0)
			return;
		n = $urandom_range(1, 9);
		s_axis_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// one argument transfer; the seed and expected hash advance on acceptance
	task automatic send_arg(input logic [63:0] arg, input logic last);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= arg;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		model_seed = model_seed * LCG_MUL + arg_mix(arg) + LCG_ADD;
		if (last) begin
			hash_q.push_back(seed_to_hash(model_seed));
			model_seed = 32'd0;
		end
		idle_burst();
	endtask

	function automatic logic [63:0] rand_arg();
		logic [63:0] a;
		a = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1, 2, 3: ;
			4, 5, 6: a[62:52] = 11'(1023 + $urandom_range(0, 80) - 40);
			7: begin
				a[62:52] = 11'd0;
				a[51:0] = a[51:0] >> $urandom_range(0, 51);
			end
			8: a[62:52] = 11'($urandom_range(1, 3));
			default: begin
				a[62:52] = 11'h7ff;
				if ($urandom_range(0, 1))
					a[51:0] = 52'd0;
			end
		endcase
		return a;
	endfunction

	// result side: random stall bursts, compare each hash with the oldest expected
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (hash_q.size() == 0)
					report("unexpected hash", m_axis_tdata, 32'd0);
				else
					begin
						logic [31:0] want;
						want = hash_q.pop_front();
						if (m_axis_tdata !== want)
							report("hash_value", m_axis_tdata, want);
					end
			end
			if (stall_left > 0)
				stall_left--;
			else if (!quiet && $urandom_range(0, 4) == 0)
				stall_left = $urandom_range(1, 9);
			m_axis_tready <= (stall_left == 0);
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else if (++idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	initial begin
		int run_left;
		errors = 0;
		idle_cycles = 0;
		quiet = 1'b0;
		model_seed = 32'd0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 64'd0;
		s_axis_tlast = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_arg(directed_rows[i].arg, directed_rows[i].last);

		// random runs of 1..6 arguments, the tail without idling
		run_left = $urandom_range(1, 6);
		for (int i = 0; i < RANDOM_ARGS; i++) begin
			if (i == RANDOM_ARGS - QUIET_ARGS)
				quiet = 1'b1;
			run_left--;
			send_arg(rand_arg(), run_left == 0 || i == RANDOM_ARGS - 1);
			if (run_left == 0)
				run_left = $urandom_range(1, 6);
		end
		s_axis_tvalid <= 1'b0;

		while (hash_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

FILE: files.f
rtl/mah_pkg.sv
rtl/mah_front.sv
rtl/mah_fifo.sv
rtl/mah_back.sv
rtl/multi_argument_hash.sv
rtl/mah_checker.sv
dv/tb.sv
